// ===== rtl/ata_pio_lba28_read_sequencer_macros.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef ATA_PIO_LBA28_READ_SEQUENCER_MACROS_SVH
`define ATA_PIO_LBA28_READ_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("apr assertion failed");

// Next-cycle implication, disabled during reset.
`define APR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("apr assertion failed");

`endif

// ===== rtl/apr_pkg.sv =====
package apr_pkg;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int DELAY_READS      = 4;
    localparam int STEP_W           = 9;
    localparam int POLL_W           = 24;

    // Configuration register indexes
    localparam logic [1:0] CFG_IO_BASE    = 2'd0;
    localparam logic [1:0] CFG_CTRL_BASE  = 2'd1;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd2;

    // Completion status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BSY_TO  = 2'd2;
    localparam logic [1:0] ST_DRQ_ERR = 2'd3;

    // Command block register offsets
    localparam logic [15:0] REG_DATA   = 16'd0;
    localparam logic [15:0] REG_COUNT  = 16'd2;
    localparam logic [15:0] REG_LBA0   = 16'd3;
    localparam logic [15:0] REG_LBA1   = 16'd4;
    localparam logic [15:0] REG_LBA2   = 16'd5;
    localparam logic [15:0] REG_DEVSEL = 16'd6;
    localparam logic [15:0] REG_CMD    = 16'd7;

    localparam logic [7:0] CMD_READ_SECTORS = 8'h20;

    // Status register bits
    localparam int BIT_ERR = 0;
    localparam int BIT_DRQ = 3;
    localparam int BIT_DF  = 5;
    localparam int BIT_BSY = 7;

    typedef enum logic [12:0] {
        PH_IDLE = 13'b0000000000001,
        PH_SEL  = 13'b0000000000010,
        PH_DLY1 = 13'b0000000000100,
        PH_BSY1 = 13'b0000000001000,
        PH_WCNT = 13'b0000000010000,
        PH_WL0  = 13'b0000000100000,
        PH_WL1  = 13'b0000001000000,
        PH_WL2  = 13'b0000010000000,
        PH_WCMD = 13'b0000100000000,
        PH_DLY2 = 13'b0001000000000,
        PH_BSY2 = 13'b0010000000000,
        PH_DRQ  = 13'b0100000000000,
        PH_DATA = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [STEP_W-1:0]   step_index;
        logic [POLL_W-1:0]   poll_count;
        logic [7:0]          sectors_left;
        logic [27:0]         latched_lba;
        logic [7:0]          latched_count;
    } t_seq_state;

    typedef struct packed {
        logic        mode;
        logic [31:0] lba;
        logic [7:0]  sector_count;
        logic        drive;
        logic [15:0] response_data;
    } t_item;

    typedef struct packed {
        logic        access_valid;
        logic        access_write;
        logic        access_wide;
        logic [15:0] port_address;
        logic [7:0]  write_data;
        logic        word_valid;
        logic [15:0] word_data;
        logic        done_res;
        logic [1:0]  status_code;
    } t_result;

endpackage

// ===== rtl/apr_step.sv =====
module apr_step
    import apr_pkg::*;
(
    input  t_seq_state  i_state,
    input  t_item       i_item,
    input  logic [15:0] i_io_base,
    input  logic [15:0] i_ctrl_base,
    input  logic [23:0] i_poll_limit,
    output t_seq_state  o_state,
    output logic        o_emit,
    output t_result     o_result
);

    logic [STEP_W-1:0] w_step_inc;
    logic [7:0]        w_status;
    logic [7:0]        w_sectors_dec;

    assign w_step_inc    = i_state.step_index + STEP_W'(1);
    assign w_status      = i_item.response_data[7:0];
    assign w_sectors_dec = i_state.sectors_left - 8'd1;

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;

        if (!i_item.mode) begin
            if (i_state.phase == PH_IDLE) begin
                o_emit = 1'b1;
                if (i_item.sector_count == 8'd0 || i_item.lba[31:28] != 4'd0) begin
                    o_result.done_res    = 1'b1;
                    o_result.status_code = ST_INVALID;
                    o_state.step_index   = '0;
                    o_state.poll_count   = '0;
                end else begin
                    o_state.latched_lba   = i_item.lba[27:0];
                    o_state.latched_count = i_item.sector_count;
                    o_state.sectors_left  = i_item.sector_count;
                    o_state.phase         = PH_SEL;
                    o_result.access_valid = 1'b1;
                    o_result.access_write = 1'b1;
                    o_result.port_address = i_io_base + REG_DEVSEL;
                    o_result.write_data   = {3'b111, i_item.drive, i_item.lba[27:24]};
                end
            end
        end else begin
            o_emit = 1'b1;
            case (i_state.phase)
                PH_SEL, PH_WCMD: begin
                    o_state.phase         = (i_state.phase == PH_SEL) ? PH_DLY1 : PH_DLY2;
                    o_state.step_index    = '0;
                    o_result.access_valid = 1'b1;
                    o_result.port_address = i_ctrl_base;
                end
                PH_DLY1, PH_DLY2: begin
                    o_result.access_valid = 1'b1;
                    if (w_step_inc < STEP_W'(DELAY_READS)) begin
                        o_state.step_index    = w_step_inc;
                        o_result.port_address = i_ctrl_base;
                    end else begin
                        // start the BSY wait with its first status read
                        o_state.step_index    = '0;
                        o_state.phase         = (i_state.phase == PH_DLY1) ? PH_BSY1 : PH_BSY2;
                        o_state.poll_count    = POLL_W'(1);
                        o_result.port_address = i_io_base + REG_CMD;
                    end
                end
                PH_BSY1, PH_BSY2, PH_DRQ: begin
                    if (i_state.phase == PH_DRQ && (w_status[BIT_ERR] || w_status[BIT_DF])) begin
                        o_result.done_res    = 1'b1;
                        o_result.status_code = ST_DRQ_ERR;
                        o_state.phase        = PH_IDLE;
                        o_state.step_index   = '0;
                        o_state.poll_count   = '0;
                    end else if (i_state.phase == PH_BSY1 && !w_status[BIT_BSY]) begin
                        o_state.phase         = PH_WCNT;
                        o_result.access_valid = 1'b1;
                        o_result.access_write = 1'b1;
                        o_result.port_address = i_io_base + REG_COUNT;
                        o_result.write_data   = i_state.latched_count;
                    end else if (i_state.phase == PH_BSY2 && !w_status[BIT_BSY]) begin
                        o_state.phase         = PH_DRQ;
                        o_state.poll_count    = POLL_W'(1);
                        o_result.access_valid = 1'b1;
                        o_result.port_address = i_io_base + REG_CMD;
                    end else if (i_state.phase == PH_DRQ && w_status[BIT_DRQ]) begin
                        o_state.phase         = PH_DATA;
                        o_state.step_index    = '0;
                        o_result.access_valid = 1'b1;
                        o_result.access_wide  = 1'b1;
                        o_result.port_address = i_io_base + REG_DATA;
                    end else if (i_state.poll_count >= i_poll_limit) begin
                        o_result.done_res    = 1'b1;
                        o_result.status_code = (i_state.phase == PH_DRQ) ? ST_DRQ_ERR
                                                                          : ST_BSY_TO;
                        o_state.phase        = PH_IDLE;
                        o_state.step_index   = '0;
                        o_state.poll_count   = '0;
                    end else begin
                        o_state.poll_count    = i_state.poll_count + POLL_W'(1);
                        o_result.access_valid = 1'b1;
                        o_result.port_address = i_io_base + REG_CMD;
                    end
                end
                PH_WCNT: begin
                    o_state.phase         = PH_WL0;
                    o_result.access_valid = 1'b1;
                    o_result.access_write = 1'b1;
                    o_result.port_address = i_io_base + REG_LBA0;
                    o_result.write_data   = i_state.latched_lba[7:0];
                end
                PH_WL0: begin
                    o_state.phase         = PH_WL1;
                    o_result.access_valid = 1'b1;
                    o_result.access_write = 1'b1;
                    o_result.port_address = i_io_base + REG_LBA1;
                    o_result.write_data   = i_state.latched_lba[15:8];
                end
                PH_WL1: begin
                    o_state.phase         = PH_WL2;
                    o_result.access_valid = 1'b1;
                    o_result.access_write = 1'b1;
                    o_result.port_address = i_io_base + REG_LBA2;
                    o_result.write_data   = i_state.latched_lba[23:16];
                end
                PH_WL2: begin
                    o_state.phase         = PH_WCMD;
                    o_result.access_valid = 1'b1;
                    o_result.access_write = 1'b1;
                    o_result.port_address = i_io_base + REG_CMD;
                    o_result.write_data   = CMD_READ_SECTORS;
                end
                PH_DATA: begin
                    o_result.word_valid = 1'b1;
                    o_result.word_data  = i_item.response_data;
                    if (w_step_inc < STEP_W'(WORDS_PER_SECTOR)) begin
                        o_state.step_index    = w_step_inc;
                        o_result.access_valid = 1'b1;
                        o_result.access_wide  = 1'b1;
                        o_result.port_address = i_io_base + REG_DATA;
                    end else begin
                        o_state.step_index   = '0;
                        o_state.sectors_left = w_sectors_dec;
                        if (w_sectors_dec == 8'd0) begin
                            o_result.done_res    = 1'b1;
                            o_result.status_code = ST_OK;
                            o_state.phase        = PH_IDLE;
                            o_state.poll_count   = '0;
                        end else begin
                            o_state.phase         = PH_BSY2;
                            o_state.poll_count    = POLL_W'(1);
                            o_result.access_valid = 1'b1;
                            o_result.port_address = i_io_base + REG_CMD;
                        end
                    end
                end
                default: begin
                    // response while idle: drop it
                    o_emit = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/ata_pio_lba28_read_sequencer.sv =====
// Host-side ATA PIO READ SECTORS (28-bit LBA) sequencer. Send a start transaction
// (mode 0) with lba, sector_count and drive; the block answers with one result per
// bus access it wants performed, and each access must be answered by one response
// transaction (mode 1) carrying the read data, which may be any value for writes.
// The sequence is drive select, four control-port delay reads, a BSY poll, the
// count/LBA/command writes, four more delay reads, then per sector a BSY poll, a
// DRQ poll and 256 wide data reads; each data word comes back in the result that
// follows its response, and the last one carries done_res with status 0. A zero
// count or an lba above 28 bits finishes at once with status 1; a poll that hits
// poll_limit status reads finishes with 2 (BSY wait) or 3 (DRQ wait, also on ERR
// or DF). Starts while busy and responses while idle are dropped without a result.
// Throughput is one transaction per clock: an input register feeds combinational
// next-step logic (apr_step) into the result register, so an item passes through
// the input register and then the result register, and a new one can enter
// every cycle unless the result register is stalled. Configuration writes take
// effect on the next edge and should be made while the sequencer is idle.
`include "ata_pio_lba28_read_sequencer_macros.svh"

module ata_pio_lba28_read_sequencer
    import apr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [31:0] i_lba,
    input  logic [7:0]  i_sector_count,
    input  logic        i_drive,
    input  logic [15:0] i_response_data,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_access_valid,
    output logic        o_access_write,
    output logic        o_access_wide,
    output logic [15:0] o_port_address,
    output logic [7:0]  o_write_data,
    output logic        o_word_valid,
    output logic [15:0] o_word_data,
    output logic        o_done_res,
    output logic [1:0]  o_status_code
);

    logic [15:0] r_io_base;
    logic [15:0] r_ctrl_base;
    logic [23:0] r_poll_limit;

    logic        r_in_valid;
    t_item       r_item;
    t_seq_state  r_state;
    logic        r_out_valid;
    t_result     r_result;

    logic        w_advance;
    logic        w_accept;
    logic        w_emit;
    t_seq_state  n_state;
    t_result     n_result;

    // Process the held item when the result register is empty or being emptied.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    apr_step u_step (
        .i_state      (r_state),
        .i_item       (r_item),
        .i_io_base    (r_io_base),
        .i_ctrl_base  (r_ctrl_base),
        .i_poll_limit (r_poll_limit),
        .o_state      (n_state),
        .o_emit       (w_emit),
        .o_result     (n_result)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_io_base    <= 16'h01F0;
            r_ctrl_base  <= 16'h03F6;
            r_poll_limit <= 24'd1000000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IO_BASE:    r_io_base    <= i_cfg_data[15:0];
                CFG_CTRL_BASE:  r_ctrl_base  <= i_cfg_data[15:0];
                CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register: hold the transaction until the step logic takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= '{mode: i_mode, lba: i_lba, sector_count: i_sector_count,
                        drive: i_drive, response_data: i_response_data};
        end
    end

    // Sequencer state: advance once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register: load on a processed transaction that yields a result,
    // drop once the result has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_access_valid = r_result.access_valid;
    assign o_access_write = r_result.access_write;
    assign o_access_wide  = r_result.access_wide;
    assign o_port_address = r_result.port_address;
    assign o_write_data   = r_result.write_data;
    assign o_word_valid   = r_result.word_valid;
    assign o_word_data    = r_result.word_data;
    assign o_done_res     = r_result.done_res;
    assign o_status_code  = r_result.status_code;

    // A finished request never asks for another bus access.
    `APR_ASSERT_NOW(a_done_no_access, i_clk, i_rst_n, o_out_valid && o_done_res, !o_access_valid)
    // A failure status only appears on a finishing result.
    `APR_ASSERT_NOW(a_status_done, i_clk, i_rst_n, o_out_valid && o_status_code != ST_OK, o_done_res && !o_word_valid)
    // Data words come with a wide read, a status read or no access, never with a write.
    `APR_ASSERT_NOW(a_word_no_write, i_clk, i_rst_n, o_out_valid && o_word_valid, !o_access_write)
    // A held transaction is not lost or altered while the result side stalls.
    `APR_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid && $stable(r_item))

endmodule
